/* src/fahjc_pkg.sv */
package fahjc_pkg;

   localparam int NUM_AXES    = 4;
   localparam int LIMIT_WIDTH = 12;
   localparam int BYTE_WIDTH  = 8;

   // rotation, main arm, gripper, gripper arm
   localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET [NUM_AXES] = '{
      12'd1800, 12'd500, 12'd450, 12'd3000
   };

   // jog key codes
   localparam logic [BYTE_WIDTH-1:0] KEY_ROTATE_LEFT      = 8'h61;
   localparam logic [BYTE_WIDTH-1:0] KEY_ROTATE_RIGHT     = 8'h64;
   localparam logic [BYTE_WIDTH-1:0] KEY_ARM_UP           = 8'h77;
   localparam logic [BYTE_WIDTH-1:0] KEY_ARM_DOWN         = 8'h73;
   localparam logic [BYTE_WIDTH-1:0] KEY_GRIP_OPEN        = 8'h66;
   localparam logic [BYTE_WIDTH-1:0] KEY_GRIP_CLOSE       = 8'h67;
   localparam logic [BYTE_WIDTH-1:0] KEY_GRIPPER_ARM_UP   = 8'h6d;
   localparam logic [BYTE_WIDTH-1:0] KEY_GRIPPER_ARM_DOWN = 8'h6e;

   typedef struct packed {
      logic toward;
      logic away;
   } axis_cmd_type;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] ctrl_byte;
      logic [BYTE_WIDTH-1:0] enable_byte;
      logic                  write_valid;
      logic [NUM_AXES-1:0]   switches_hit;
      logic                  move_refused;
      logic                  homing_done;
   } result_type;

endpackage

/* src/four_axis_homing_jog_controller.sv */
// Four-axis homing and jog controller. Each item is one poll of the limit-switch byte with an
// optional key code. After reset the block homes rotation, main arm, gripper and gripper arm in
// turn, stepping each until its active-low switch reads hit, then jogs axes on keys a/d, w/s,
// f/g and m/n, refusing moves away from a switch at the csr soft limits. One item is taken every
// clock while rsp_stall does not hold the pipe: an item waits in the input register while its
// result is computed, then the phase, port bytes and four step counters update as its result is
// loaded into the output register, and back-pressure from rsp_stall holds both stages.
module four_axis_homing_jog_controller #(
   parameter int COUNT_WIDTH = 13
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [fahjc_pkg::BYTE_WIDTH-1:0]  req_switch_byte,
   input  logic                              req_key_pressed,
   input  logic [fahjc_pkg::BYTE_WIDTH-1:0]  req_key_code,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [fahjc_pkg::BYTE_WIDTH-1:0]  rsp_ctrl_byte,
   output logic [fahjc_pkg::BYTE_WIDTH-1:0]  rsp_enable_byte,
   output logic                              rsp_write_valid,
   output logic [fahjc_pkg::NUM_AXES-1:0]    rsp_switches_hit,
   output logic                              rsp_move_refused,
   output logic                              rsp_homing_done,
   input  logic                              csr_write_enable,
   input  logic [1:0]                        csr_index,
   input  logic [fahjc_pkg::LIMIT_WIDTH-1:0] csr_write_data
);
   import fahjc_pkg::*;

   logic                   in_valid_ff;
   logic                   in_valid_in;
   logic [BYTE_WIDTH-1:0]  switch_ff;
   logic                   key_pressed_ff;
   logic [BYTE_WIDTH-1:0]  key_code_ff;
   logic                   out_valid_ff;
   logic                   out_valid_in;
   result_type             result_ff;
   result_type             result;
   logic [LIMIT_WIDTH-1:0] limit_ff [NUM_AXES];
   logic                   advance;
   logic                   step;
   logic                   req_take;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (step) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         switch_ff      <= req_switch_byte;
         key_pressed_ff <= req_key_pressed;
         key_code_ff    <= req_key_code;
      end
      if (step) begin
         result_ff <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            limit_ff[i] <= LIMIT_RESET[i];
         end
      end else if (csr_write_enable) begin
         limit_ff[csr_index] <= csr_write_data;
      end
   end

   fahjc_core #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .switch_byte(switch_ff),
      .key_pressed(key_pressed_ff),
      .key_code   (key_code_ff),
      .limit      (limit_ff),
      .result     (result)
   );

   assign rsp_valid        = out_valid_ff;
   assign rsp_ctrl_byte    = result_ff.ctrl_byte;
   assign rsp_enable_byte  = result_ff.enable_byte;
   assign rsp_write_valid  = result_ff.write_valid;
   assign rsp_switches_hit = result_ff.switches_hit;
   assign rsp_move_refused = result_ff.move_refused;
   assign rsp_homing_done  = result_ff.homing_done;

`ifndef SYNTHESIS
   a_refuse_writes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_move_refused |-> rsp_write_valid && rsp_homing_done)
      else $error("refused move without write in jog phase");

   a_item_kept: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !step |=> in_valid_ff)
      else $error("stalled item dropped from input register");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(result_ff))
      else $error("stalled result changed");
`endif

endmodule

/* src/fahjc_axis.sv */
module fahjc_axis #(
   parameter int COUNT_WIDTH = 13
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               step,
   input  logic                               run,
   input  logic                               hit,
   input  fahjc_pkg::axis_cmd_type            cmd,
   input  logic [fahjc_pkg::LIMIT_WIDTH-1:0]  limit,
   output logic                               away_ok
);
   import fahjc_pkg::*;

   localparam int CMP_WIDTH = COUNT_WIDTH + 1;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
   localparam logic [COUNT_WIDTH-1:0] COUNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
   localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;
   logic [COUNT_WIDTH-1:0] base;
   logic signed [CMP_WIDTH-1:0] base_cmp;
   logic signed [CMP_WIDTH-1:0] limit_cmp;

   // an active switch zeroes the count before any jog
   assign base      = (run && hit) ? '0 : count_ff;
   assign base_cmp  = signed'({base[COUNT_WIDTH-1], base});
   assign limit_cmp = signed'({{(CMP_WIDTH-LIMIT_WIDTH){1'b0}}, limit});
   assign away_ok   = base_cmp < limit_cmp;

   always_comb begin
      count_in = base;
      if (cmd.toward && (base != COUNT_MIN)) begin
         count_in = base - COUNT_ONE;
      end else if (cmd.away && (base != COUNT_MAX)) begin
         count_in = base + COUNT_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (step && run) begin
         count_ff <= count_in;
      end
   end

endmodule

/* src/fahjc_core.sv */
module fahjc_core #(
   parameter int COUNT_WIDTH = 13
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step,
   input  logic [fahjc_pkg::BYTE_WIDTH-1:0]  switch_byte,
   input  logic                              key_pressed,
   input  logic [fahjc_pkg::BYTE_WIDTH-1:0]  key_code,
   input  logic [fahjc_pkg::LIMIT_WIDTH-1:0] limit [fahjc_pkg::NUM_AXES],
   output fahjc_pkg::result_type             result
);
   import fahjc_pkg::*;

   localparam logic [BYTE_WIDTH-1:0] ALL_OFF   = 8'hff;
   localparam logic [BYTE_WIDTH-1:0] DIR_SET   = 8'h02;
   localparam logic [BYTE_WIDTH-1:0] DIR_CLEAR = 8'hfd;
   localparam logic [BYTE_WIDTH-1:0] AXIS_MASK [NUM_AXES] = '{
      8'h7f, 8'hbf, 8'hdf, 8'hef
   };

   localparam logic [1:0] AXIS_ROTATION    = 2'd0;
   localparam logic [1:0] AXIS_MAIN_ARM    = 2'd1;
   localparam logic [1:0] AXIS_GRIPPER     = 2'd2;
   localparam logic [1:0] AXIS_GRIPPER_ARM = 2'd3;

   logic [2:0]            phase_ff;
   logic [2:0]            phase_in;
   logic [BYTE_WIDTH-1:0] ctrl_ff;
   logic [BYTE_WIDTH-1:0] ctrl_in;
   logic [BYTE_WIDTH-1:0] enable_ff;
   logic [BYTE_WIDTH-1:0] enable_in;
   logic [NUM_AXES-1:0]   hit;
   logic [NUM_AXES-1:0]   away_ok;
   axis_cmd_type          cmd [NUM_AXES];
   logic                  run;
   logic                  write_valid;
   logic                  refused;
   logic [1:0]            homing_axis;
   logic [1:0]            jog_axis;
   logic                  jog_high;
   logic                  jog_toward;
   logic                  jog_away;

   assign run         = phase_ff[2];
   assign homing_axis = phase_ff[1:0];

   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         hit[i] = ((switch_byte | AXIS_MASK[i]) == AXIS_MASK[i]);
      end
   end

   always_comb begin
      jog_axis   = AXIS_ROTATION;
      jog_high   = 1'b0;
      jog_toward = 1'b0;
      jog_away   = 1'b0;
      case (key_code)
         KEY_ROTATE_LEFT: begin
            jog_toward = 1'b1;
         end
         KEY_ROTATE_RIGHT: begin
            jog_away = 1'b1;
            jog_high = 1'b1;
         end
         KEY_ARM_UP: begin
            jog_axis   = AXIS_MAIN_ARM;
            jog_toward = 1'b1;
         end
         KEY_ARM_DOWN: begin
            jog_axis = AXIS_MAIN_ARM;
            jog_away = 1'b1;
            jog_high = 1'b1;
         end
         KEY_GRIP_OPEN: begin
            jog_axis   = AXIS_GRIPPER;
            jog_toward = 1'b1;
         end
         KEY_GRIP_CLOSE: begin
            jog_axis = AXIS_GRIPPER;
            jog_away = 1'b1;
            jog_high = 1'b1;
         end
         KEY_GRIPPER_ARM_UP: begin
            jog_axis   = AXIS_GRIPPER_ARM;
            jog_toward = 1'b1;
            jog_high   = 1'b1;
         end
         KEY_GRIPPER_ARM_DOWN: begin
            jog_axis = AXIS_GRIPPER_ARM;
            jog_away = 1'b1;
         end
         default: begin
            jog_toward = 1'b0;
         end
      endcase
   end

   always_comb begin
      phase_in    = phase_ff;
      ctrl_in     = ctrl_ff;
      enable_in   = enable_ff;
      write_valid = 1'b0;
      refused     = 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
         cmd[i] = '0;
      end
      if (!run) begin
         if (hit[homing_axis]) begin
            ctrl_in   = ALL_OFF;
            enable_in = ALL_OFF;
            phase_in  = phase_ff + 3'd1;
         end else begin
            enable_in   = enable_ff & AXIS_MASK[homing_axis];
            ctrl_in     = (homing_axis == AXIS_GRIPPER_ARM) ? (ctrl_ff | DIR_SET)
                                                            : (ctrl_ff & DIR_CLEAR);
            write_valid = 1'b1;
         end
      end else if (key_pressed) begin
         write_valid = 1'b1;
         if (jog_toward) begin
            if (!hit[jog_axis]) begin
               enable_in             = enable_ff & AXIS_MASK[jog_axis];
               ctrl_in               = jog_high ? (ctrl_ff | DIR_SET) : (ctrl_ff & DIR_CLEAR);
               cmd[jog_axis].toward  = 1'b1;
            end else if (key_code == KEY_ROTATE_LEFT) begin
               ctrl_in   = ALL_OFF;
               enable_in = ALL_OFF;
            end
         end else if (jog_away) begin
            if (away_ok[jog_axis]) begin
               enable_in          = enable_ff & AXIS_MASK[jog_axis];
               ctrl_in            = jog_high ? (ctrl_ff | DIR_SET) : (ctrl_ff & DIR_CLEAR);
               cmd[jog_axis].away = 1'b1;
            end else begin
               refused = 1'b1;
            end
         end
      end else begin
         ctrl_in   = ALL_OFF;
         enable_in = ALL_OFF;
      end
   end

   for (genvar g = 0; g < NUM_AXES; g++) begin : g_axis
      fahjc_axis #(
         .COUNT_WIDTH(COUNT_WIDTH)
      ) u_axis (
         .clock  (clock),
         .reset  (reset),
         .step   (step),
         .run    (run),
         .hit    (hit[g]),
         .cmd    (cmd[g]),
         .limit  (limit[g]),
         .away_ok(away_ok[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= '0;
         ctrl_ff   <= ALL_OFF;
         enable_ff <= ALL_OFF;
      end else if (step) begin
         phase_ff  <= phase_in;
         ctrl_ff   <= ctrl_in;
         enable_ff <= enable_in;
      end
   end

   assign result.ctrl_byte    = ctrl_in;
   assign result.enable_byte  = enable_in;
   assign result.write_valid  = write_valid;
   assign result.switches_hit = hit;
   assign result.move_refused = refused;
   assign result.homing_done  = phase_in[2];

`ifndef SYNTHESIS
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      phase_ff[2] |=> phase_ff[2])
      else $error("homing phase left the jog phase");

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(phase_ff) && $stable(ctrl_ff) && $stable(enable_ff))
      else $error("state changed without an item");

   a_quiet_off: assert property (@(posedge clock) disable iff (reset)
      step && !result.write_valid |->
         (result.ctrl_byte == ALL_OFF) && (result.enable_byte == ALL_OFF))
      else $error("port bytes not released on a poll without write");
`endif

endmodule

/* tb/four_axis_homing_jog_controller_tb.sv */
module four_axis_homing_jog_controller_tb;
   import fahjc_pkg::*;

   localparam int COUNT_WIDTH  = 13;
   localparam int CNT_MAX      = 2 ** (COUNT_WIDTH - 1) - 1;
   localparam int CNT_MIN      = -CNT_MAX - 1;
   localparam int IDLE_LIMIT   = 2000;
   localparam int LONG_HOLD    = 150;
   localparam int DRAIN_CYCLES = 4;
   localparam int WALK_STEPS   = 40;

   localparam logic [2:0] PHASE_JOG = 3'd4;

   localparam int AX_ROTATION    = 0;
   localparam int AX_MAIN_ARM    = 1;
   localparam int AX_GRIPPER     = 2;
   localparam int AX_GRIPPER_ARM = 3;

   localparam logic [BYTE_WIDTH-1:0] ALL_OFF   = 8'hff;
   localparam logic [BYTE_WIDTH-1:0] DIR_BIT   = 8'h02;
   localparam logic [BYTE_WIDTH-1:0] NO_SWITCH = 8'hff;
   localparam logic [BYTE_WIDTH-1:0] AXIS_MASK [NUM_AXES] = '{8'h7f, 8'hbf, 8'hdf, 8'hef};

   localparam logic [BYTE_WIDTH-1:0] JOG_KEYS [8] = '{
      KEY_ROTATE_LEFT, KEY_ROTATE_RIGHT, KEY_ARM_UP, KEY_ARM_DOWN,
      KEY_GRIP_OPEN, KEY_GRIP_CLOSE, KEY_GRIPPER_ARM_UP, KEY_GRIPPER_ARM_DOWN
   };

   typedef enum logic [1:0] {
      REG_ROTATION_LIMIT, REG_MAIN_ARM_LIMIT, REG_GRIPPER_LIMIT, REG_GRIPPER_ARM_LIMIT
   } limit_reg_type;

   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_stall;
   logic [BYTE_WIDTH-1:0]  req_switch_byte  = NO_SWITCH;
   logic                   req_key_pressed  = 1'b0;
   logic [BYTE_WIDTH-1:0]  req_key_code     = '0;
   logic                   rsp_valid;
   logic                   rsp_stall        = 1'b0;
   logic [BYTE_WIDTH-1:0]  rsp_ctrl_byte;
   logic [BYTE_WIDTH-1:0]  rsp_enable_byte;
   logic                   rsp_write_valid;
   logic [NUM_AXES-1:0]    rsp_switches_hit;
   logic                   rsp_move_refused;
   logic                   rsp_homing_done;
   logic                   csr_write_enable = 1'b0;
   logic [1:0]             csr_index        = '0;
   logic [LIMIT_WIDTH-1:0] csr_write_data   = '0;

   four_axis_homing_jog_controller #(.COUNT_WIDTH(COUNT_WIDTH)) uut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // controller state as the block should hold it
   logic [2:0]                    home_phase;
   logic [BYTE_WIDTH-1:0]         ctrl_reg;
   logic [BYTE_WIDTH-1:0]         enable_reg;
   logic signed [COUNT_WIDTH-1:0] step_count [NUM_AXES];
   logic [LIMIT_WIDTH-1:0]        soft_limit [NUM_AXES];

   result_type due_results [$];
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   logic hold_trigger     = 1'b0;
   int hold_left          = 0;
   int idle_cycles        = 0;
   int mismatches         = 0;
   int results_checked    = 0;
   int refusals_seen      = 0;
   int pulses_seen        = 0;

   function automatic void drive_axis(int axis, logic dir_high);
      enable_reg &= AXIS_MASK[axis];
      if (dir_high) begin
         ctrl_reg |= DIR_BIT;
      end else begin
         ctrl_reg &= ~DIR_BIT;
      end
   endfunction

   function automatic void jog_toward(int axis, logic dir_high);
      drive_axis(axis, dir_high);
      if (int'(step_count[axis]) > CNT_MIN) begin
         step_count[axis] = step_count[axis] - COUNT_WIDTH'(1);
      end
   endfunction

   function automatic logic jog_away(int axis, logic dir_high);
      if (int'(step_count[axis]) < int'(soft_limit[axis])) begin
         drive_axis(axis, dir_high);
         if (int'(step_count[axis]) < CNT_MAX) begin
            step_count[axis] = step_count[axis] + COUNT_WIDTH'(1);
         end
         return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void all_off();
      ctrl_reg   = ALL_OFF;
      enable_reg = ALL_OFF;
   endfunction

   function automatic result_type step_controller(logic [BYTE_WIDTH-1:0] sw, logic key,
                                                  logic [BYTE_WIDTH-1:0] code);
      result_type r;
      logic [NUM_AXES-1:0] hit;
      r = '0;
      for (int i = 0; i < NUM_AXES; i++) begin
         hit[i] = (sw | AXIS_MASK[i]) == AXIS_MASK[i];
      end
      if (home_phase < PHASE_JOG) begin
         if (hit[home_phase]) begin
            all_off();
            home_phase = home_phase + 3'd1;
         end else begin
            drive_axis(int'(home_phase), int'(home_phase) == AX_GRIPPER_ARM);
            r.write_valid = 1'b1;
         end
      end else begin
         for (int i = 0; i < NUM_AXES; i++) begin
            if (hit[i]) step_count[i] = '0;
         end
         if (key) begin
            case (code)
               KEY_ROTATE_LEFT: begin
                  if (!hit[AX_ROTATION]) jog_toward(AX_ROTATION, 1'b0);
                  else all_off();
               end
               KEY_ROTATE_RIGHT: r.move_refused = jog_away(AX_ROTATION, 1'b1);
               KEY_ARM_UP: begin
                  if (!hit[AX_MAIN_ARM]) jog_toward(AX_MAIN_ARM, 1'b0);
               end
               KEY_ARM_DOWN: r.move_refused = jog_away(AX_MAIN_ARM, 1'b1);
               KEY_GRIP_OPEN: begin
                  if (!hit[AX_GRIPPER]) jog_toward(AX_GRIPPER, 1'b0);
               end
               KEY_GRIP_CLOSE: r.move_refused = jog_away(AX_GRIPPER, 1'b1);
               KEY_GRIPPER_ARM_UP: begin
                  if (!hit[AX_GRIPPER_ARM]) jog_toward(AX_GRIPPER_ARM, 1'b1);
               end
               KEY_GRIPPER_ARM_DOWN: r.move_refused = jog_away(AX_GRIPPER_ARM, 1'b0);
               default: ;
            endcase
            r.write_valid = 1'b1;
         end else begin
            all_off();
         end
      end
      r.ctrl_byte    = ctrl_reg;
      r.enable_byte  = enable_reg;
      r.switches_hit = hit;
      r.homing_done  = home_phase >= PHASE_JOG;
      return r;
   endfunction

   function automatic void check_field(string field, int want, int got);
      if (want != got) begin
         $display("%0t: %s expected 'h%0h, got 'h%0h", $time, field, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_results.size() == 0) begin
            $display("%0t: result with none expected, expected nothing, got ctrl 'h%0h",
                     $time, rsp_ctrl_byte);
            mismatches++;
         end else begin
            want = due_results.pop_front();
            check_field("ctrl_byte", want.ctrl_byte, rsp_ctrl_byte);
            check_field("enable_byte", want.enable_byte, rsp_enable_byte);
            check_field("write_valid", want.write_valid, rsp_write_valid);
            check_field("switches_hit", want.switches_hit, rsp_switches_hit);
            check_field("move_refused", want.move_refused, rsp_move_refused);
            check_field("homing_done", want.homing_done, rsp_homing_done);
            results_checked++;
            refusals_seen += want.move_refused;
            pulses_seen += want.write_valid;
         end
      end
   end

   always @(negedge clock) begin
      if (hold_trigger) begin
         hold_left    = LONG_HOLD;
         hold_trigger = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= $urandom_range(99) < receiver_stall_pct;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
            $display("Mismatches found");
            $finish;
         end
      end
   end

   task automatic poll(input logic [BYTE_WIDTH-1:0] sw, input logic key,
                       input logic [BYTE_WIDTH-1:0] code);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_switch_byte <= sw;
      req_key_pressed <= key;
      req_key_code    <= code;
      do @(posedge clock); while (req_stall);
      due_results.push_back(step_controller(sw, key, code));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(limit_reg_type idx, logic [LIMIT_WIDTH-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      soft_limit[idx] = value;
   endtask

   task automatic random_poll();
      int pick;
      logic [BYTE_WIDTH-1:0] sw;
      pick = $urandom_range(99);
      sw = {4'hf, 4'($urandom)};
      if ($urandom_range(3) == 0) sw[4 + $urandom_range(3)] = 1'b0;
      if (pick < 70) begin
         poll(sw, 1'b1, JOG_KEYS[$urandom_range(7)]);
      end else if (pick < 80) begin
         poll(8'($urandom), 1'b0, 8'($urandom));
      end else if (pick < 90) begin
         poll(8'($urandom), 1'b1, 8'($urandom));
      end else begin
         poll(8'($urandom), 1'b1, JOG_KEYS[$urandom_range(7)]);
      end
   endtask

   task automatic test_homing();
      poll(NO_SWITCH, 1'b0, 8'h00);
      poll(NO_SWITCH, 1'b1, KEY_ROTATE_RIGHT);
      poll(AXIS_MASK[AX_ROTATION], 1'b0, 8'h00);
      poll(AXIS_MASK[AX_ROTATION], 1'b1, KEY_ARM_DOWN);
      poll(AXIS_MASK[AX_MAIN_ARM], 1'b0, 8'h00);
      poll(8'h00, 1'b1, 8'hff);
      poll(NO_SWITCH, 1'b0, 8'h00);
      poll(AXIS_MASK[AX_GRIPPER_ARM], 1'b0, 8'h00);
      wait_drained();
   endtask

   task automatic test_jog_keys();
      poll(NO_SWITCH, 1'b0, KEY_ROTATE_RIGHT);
      foreach (JOG_KEYS[k]) poll(NO_SWITCH, 1'b1, JOG_KEYS[k]);
      poll(AXIS_MASK[AX_ROTATION], 1'b1, KEY_ROTATE_LEFT);
      poll(AXIS_MASK[AX_MAIN_ARM], 1'b1, KEY_ARM_UP);
      poll(AXIS_MASK[AX_GRIPPER], 1'b1, KEY_GRIP_OPEN);
      poll(AXIS_MASK[AX_GRIPPER_ARM], 1'b1, KEY_GRIPPER_ARM_UP);
      poll(8'h00, 1'b1, 8'h00);
      poll(8'h0f, 1'b1, 8'hff);
      wait_drained();
   endtask

   task automatic test_soft_limits();
      write_limit(REG_ROTATION_LIMIT, '0);
      write_limit(REG_MAIN_ARM_LIMIT, '0);
      write_limit(REG_GRIPPER_LIMIT, '0);
      write_limit(REG_GRIPPER_ARM_LIMIT, '0);
      poll(8'h0f, 1'b0, 8'h00);
      poll(NO_SWITCH, 1'b1, KEY_ROTATE_RIGHT);
      poll(NO_SWITCH, 1'b1, KEY_ARM_DOWN);
      poll(NO_SWITCH, 1'b1, KEY_GRIP_CLOSE);
      poll(NO_SWITCH, 1'b1, KEY_GRIPPER_ARM_DOWN);
      wait_drained();
      write_limit(REG_ROTATION_LIMIT, '1);
      write_limit(REG_MAIN_ARM_LIMIT, 12'd1);
      poll(NO_SWITCH, 1'b1, KEY_ROTATE_RIGHT);
      poll(NO_SWITCH, 1'b1, KEY_ARM_DOWN);
      poll(NO_SWITCH, 1'b1, KEY_ARM_DOWN);
      wait_drained();
   endtask

   task automatic test_count_walk();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      write_limit(REG_MAIN_ARM_LIMIT, '0);
      write_limit(REG_GRIPPER_ARM_LIMIT, '1);
      poll(8'h0f, 1'b0, 8'h00);
      // drive main arm below zero, then climb back to the limit
      repeat (WALK_STEPS) poll(NO_SWITCH, 1'b1, KEY_ARM_UP);
      repeat (WALK_STEPS + 5) poll(NO_SWITCH, 1'b1, KEY_ARM_DOWN);
      repeat (WALK_STEPS) poll(NO_SWITCH, 1'b1, KEY_GRIPPER_ARM_DOWN);
      wait_drained();
   endtask

   task automatic test_backpressure();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_trigger = 1'b1;
      repeat (24) random_poll();
      wait_drained();
      repeat (24) random_poll();
      wait_drained();
   endtask

   task automatic test_random(int items, int send_pct, int recv_pct, logic extreme_limits);
      int pick;
      sender_idle_pct    = send_pct;
      receiver_stall_pct = recv_pct;
      for (int i = 0; i < NUM_AXES; i++) begin
         pick = $urandom_range(2);
         if (!extreme_limits) begin
            write_limit(limit_reg_type'(i), 12'($urandom_range(40)));
         end else if (pick == 0) begin
            write_limit(limit_reg_type'(i), '0);
         end else if (pick == 1) begin
            write_limit(limit_reg_type'(i), '1);
         end else begin
            write_limit(limit_reg_type'(i), 12'($urandom_range(15)));
         end
      end
      repeat (items) random_poll();
      wait_drained();
   endtask

   initial begin
      home_phase = '0;
      all_off();
      for (int i = 0; i < NUM_AXES; i++) begin
         step_count[i] = '0;
         soft_limit[i] = LIMIT_RESET[i];
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      sender_idle_pct    = 19;
      receiver_stall_pct = 53;
      test_homing();
      test_jog_keys();
      test_soft_limits();
      test_count_walk();
      test_backpressure();
      test_random(350, 19, 53, 1'b0);
      test_random(350, 53, 19, 1'b1);
      test_random(350, 0, 0, 1'b0);

      $display("Checked %0d polls: homing of all four axes, every jog key at and off its switch,",
               results_checked);
      $display("soft limits 0 to 4095, counts walked below zero, %0d refusals, %0d port writes.",
               refusals_seen, pulses_seen);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

/* filelist.f */
src/fahjc_pkg.sv
src/fahjc_axis.sv
src/fahjc_core.sv
src/four_axis_homing_jog_controller.sv
tb/four_axis_homing_jog_controller_tb.sv
